// File: hdl/bocd_pkg.sv
// ---------------------------------------------------------------------------
// bocd_pkg
// Shared types, codes and helpers for the box overlap collision table.
// ---------------------------------------------------------------------------
package bocd_pkg;

    // Default table depth
    localparam int SLOTS_DEF = 16;

    // Number of type classes that take part in pair checks
    localparam int         TYPES     = 8;
    localparam logic [3:0] TYPES_LIM = 4'(TYPES);
    localparam logic [7:0] TYPE_MASK = 8'((1 << TYPES) - 1);

    // Hits reported per query at most
    localparam logic [3:0] MAX_HITS = 4'd15;

    // Item operation codes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Box held as left/top edges and precomputed right/bottom edges
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] r;
        logic signed [16:0] b;
    } box_t;

    // One table entry: box plus type class and receiver flag
    typedef struct packed {
        box_t       box;
        logic [2:0] kind;
        logic       recv;
    } entry_t;

    // Sign extension of an edge to the 17-bit compare width
    function automatic logic signed [16:0] sx17(input logic signed [15:0] v);
        sx17 = {v[15], v};
    endfunction

endpackage

// File: hdl/bocd_if.sv
// ---------------------------------------------------------------------------
// bocd_if
// Handshake channels of the box overlap collision table: request items,
// result items and the pair-mask write port.
// ---------------------------------------------------------------------------
interface bocd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [15:0] left_x;
    logic [15:0] top_y;
    logic [14:0] width;
    logic [14:0] height;
    logic [2:0]  box_type;
    logic        has_receiver;

    modport source (output valid, mode, slot, left_x, top_y, width, height, box_type,
                    has_receiver, input ready);
    modport sink   (input valid, mode, slot, left_x, top_y, width, height, box_type,
                    has_receiver, output ready);
endinterface

interface bocd_rsp_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic       found;
    logic       last;

    modport source (output valid, index, found, last, input ready);
    modport sink   (input valid, index, found, last, output ready);
endinterface

interface bocd_cfg_if;
    logic        valid;
    logic        ready;
    logic [63:0] pair_mask;

    modport source (output valid, pair_mask, input ready);
    modport sink   (input valid, pair_mask, output ready);
endinterface

// File: hdl/bocd_box_ram.sv
// ---------------------------------------------------------------------------
// bocd_box_ram
// Box table storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bocd_box_ram #(
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  bocd_pkg::entry_t     wr_data,
    input  logic                 rd_en,
    input  logic [AW-1:0]        rd_addr,
    output bocd_pkg::entry_t     rd_data
);
    import bocd_pkg::*;

    entry_t mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held while not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/bocd_overlap.sv
// ---------------------------------------------------------------------------
// bocd_overlap
// Strict overlap compare of two boxes, shared by every candidate of a scan.
// ---------------------------------------------------------------------------
module bocd_overlap (
    input  bocd_pkg::box_t box_a,
    input  bocd_pkg::box_t box_b,
    output logic           hit
);
    import bocd_pkg::*;

    logic x_lo;
    logic x_hi;
    logic y_lo;
    logic y_hi;

    // Four strict edge compares; a zero-size box still hits a box that strictly spans its edge
    assign x_lo = sx17(box_a.x) < box_b.r;
    assign x_hi = box_a.r > sx17(box_b.x);
    assign y_lo = sx17(box_a.y) < box_b.b;
    assign y_hi = box_a.b > sx17(box_b.y);

    assign hit = x_lo && x_hi && y_lo && y_hi;

endmodule

// File: hdl/box_overlap_collision_table_core.sv
// ---------------------------------------------------------------------------
// box_overlap_collision_table_core
// Table of axis-aligned boxes with add, remove and overlap query.
// ---------------------------------------------------------------------------
// Usage:
//   req  : request items (mode, slot, box fields). Taken only while idle.
//   rsp  : result items (index, found, last) from a one-deep output register.
//   cfg  : pair-mask writes, always ready; write only while idle.
// Remove and mode 3 give no result. Add walks the valid bits one slot a
// cycle for the lowest free slot and gives one result; the block is idle
// again as that result is registered. Query reads the queried box, then
// one table entry a cycle, while no stall holds the scan, from the single
// read port of the box memory, and ends with a final result. Hits are held
// one back so that the final one can carry last. Reset clears the pair mask
// and marks every slot free; box contents are not cleared, so no clearing
// pass is needed. A stalled rsp halts the scan at a hit that finds the
// output register still full; the scan resumes once it drains.
// ---------------------------------------------------------------------------
module box_overlap_collision_table_core #(
    parameter int SLOTS = bocd_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bocd_req_if.sink    req,
    bocd_rsp_if.source  rsp,
    bocd_cfg_if.sink    cfg
);
    import bocd_pkg::*;

    localparam int         IW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);
    localparam logic [6:0] SLOT_LIMIT = 7'(SLOTS);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ADD  = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // Control state
    logic [2:0]       state_reg,    state_next;
    logic [SLOTS-1:0] valid_reg,    valid_next;
    logic [63:0]      pair_mask_reg;
    logic [IW-1:0]    scan_reg,     scan_next;
    logic [IW-1:0]    qslot_reg,    qslot_next;
    logic [IW-1:0]    cur_reg,      cur_next;
    logic             cur_vld_reg,  cur_vld_next;
    logic             issue_reg,    issue_next;
    logic [3:0]       hits_reg,     hits_next;
    logic             pend_vld_reg, pend_vld_next;
    logic [IW-1:0]    pend_idx_reg, pend_idx_next;
    logic             out_valid_reg, out_valid_next;

    // Payload
    entry_t           add_reg,      add_next;
    box_t             box_i_reg,    box_i_next;
    logic [7:0]       row_reg,      row_next;
    logic [3:0]       out_index_reg, out_index_next;
    logic             out_found_reg, out_found_next;
    logic             out_last_reg,  out_last_next;

    // Datapath wires
    logic             slot_ok;
    logic [IW-1:0]    slot_idx;
    logic             out_free;
    logic             rd_en;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    entry_t           rd_data;
    logic             ovl_hit;
    logic             cand_hit;
    logic             stall;
    logic             emit_en;
    logic [3:0]       emit_idx;
    logic             emit_found;
    logic             emit_last;
    logic [7:0]       row_sel;
    box_t             new_box;

    assign slot_ok  = {3'b000, req.slot} < SLOT_LIMIT;
    assign slot_idx = IW'(req.slot);
    assign out_free = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid = out_valid_reg;
    assign rsp.index = out_index_reg;
    assign rsp.found = out_found_reg;
    assign rsp.last  = out_last_reg;

    // Box as stored: right and bottom edges added once at intake
    always_comb
    begin
        new_box.x = $signed(req.left_x);
        new_box.y = $signed(req.top_y);
        new_box.r = $signed(sx17($signed(req.left_x)) + {2'b00, req.width});
        new_box.b = $signed(sx17($signed(req.top_y)) + {2'b00, req.height});
    end

    // Pair-mask row of the queried type, unused types masked off
    always_comb
    begin
        if ({1'b0, rd_data.kind} < TYPES_LIM)
        begin
            row_sel = pair_mask_reg[{rd_data.kind, 3'b000} +: 8] & TYPE_MASK;
        end
        else
        begin
            row_sel = 8'h00;
        end
    end

    // Box memory
    bocd_box_ram #(
        .DEPTH (SLOTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (scan_reg),
        .wr_data (add_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Shared overlap compare
    bocd_overlap u_ovl (
        .box_a (box_i_reg),
        .box_b (rd_data.box),
        .hit   (ovl_hit)
    );

    // Candidate qualification for the entry now at the read port
    assign cand_hit = cur_vld_reg && valid_reg[cur_reg] && (cur_reg != qslot_reg) &&
                      row_reg[rd_data.kind] && ovl_hit;
    assign stall    = (state_reg == S_SCAN) && cand_hit && pend_vld_reg && !out_free;

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        scan_next     = scan_reg;
        qslot_next    = qslot_reg;
        cur_next      = cur_reg;
        cur_vld_next  = cur_vld_reg;
        issue_next    = issue_reg;
        hits_next     = hits_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        add_next      = add_reg;
        box_i_next    = box_i_reg;
        row_next      = row_reg;
        rd_en         = 1'b0;
        rd_addr       = scan_reg;
        wr_en         = 1'b0;
        emit_en       = 1'b0;
        emit_idx      = 4'd0;
        emit_found    = 1'b0;
        emit_last     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (req.mode)
                        MODE_ADD:
                        begin
                            add_next.box  = new_box;
                            add_next.kind = req.box_type;
                            add_next.recv = req.has_receiver;
                            scan_next     = '0;
                            state_next    = S_ADD;
                        end
                        MODE_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                valid_next[slot_idx] = 1'b0;
                            end
                        end
                        MODE_QUERY:
                        begin
                            qslot_next    = slot_idx;
                            pend_vld_next = 1'b0;
                            hits_next     = 4'd0;
                            if (slot_ok && valid_reg[slot_idx])
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_idx;
                                state_next = S_LOAD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            // Walk valid bits for the lowest free slot
            S_ADD:
            begin
                if (!valid_reg[scan_reg] || (scan_reg == LAST_SLOT))
                begin
                    if (out_free)
                    begin
                        emit_en    = 1'b1;
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                        if (!valid_reg[scan_reg])
                        begin
                            wr_en                = 1'b1;
                            valid_next[scan_reg] = 1'b1;
                            emit_idx             = 4'(scan_reg);
                            emit_found           = 1'b1;
                        end
                    end
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Queried entry at the read port
            S_LOAD:
            begin
                if (!rd_data.recv)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    box_i_next   = rd_data.box;
                    row_next     = row_sel;
                    scan_next    = '0;
                    issue_next   = 1'b1;
                    cur_vld_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end

            // One entry read and one entry checked per cycle while no stall holds the scan
            S_SCAN:
            begin
                if (!stall)
                begin
                    if (cand_hit)
                    begin
                        if (pend_vld_reg)
                        begin
                            emit_en    = 1'b1;
                            emit_idx   = 4'(pend_idx_reg);
                            emit_found = 1'b1;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = cur_reg;
                        hits_next     = hits_reg + 4'd1;
                    end

                    if (cand_hit && (hits_reg == MAX_HITS - 4'd1))
                    begin
                        cur_vld_next = 1'b0;
                        issue_next   = 1'b0;
                        state_next   = S_DONE;
                    end
                    else if (issue_reg)
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = scan_reg;
                        cur_next     = scan_reg;
                        cur_vld_next = 1'b1;
                        scan_next    = scan_reg + 1'b1;
                        if (scan_reg == LAST_SLOT)
                        begin
                            issue_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cur_vld_next = 1'b0;
                        state_next   = S_DONE;
                    end
                end
            end

            // Final result of a query: held hit or not-found
            S_DONE:
            begin
                if (out_free)
                begin
                    emit_en    = 1'b1;
                    emit_idx   = pend_vld_reg ? 4'(pend_idx_reg) : 4'd0;
                    emit_found = pend_vld_reg;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_index_next = out_index_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_index_next = emit_idx;
            out_found_next = emit_found;
            out_last_next  = emit_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            pair_mask_reg <= 64'd0;
            scan_reg      <= '0;
            qslot_reg     <= '0;
            cur_reg       <= '0;
            cur_vld_reg   <= 1'b0;
            issue_reg     <= 1'b0;
            hits_reg      <= 4'd0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            scan_reg      <= scan_next;
            qslot_reg     <= qslot_next;
            cur_reg       <= cur_next;
            cur_vld_reg   <= cur_vld_next;
            issue_reg     <= issue_next;
            hits_reg      <= hits_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                pair_mask_reg <= cfg.pair_mask;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        add_reg       <= add_next;
        box_i_reg     <= box_i_next;
        row_reg       <= row_next;
        out_index_reg <= out_index_next;
        out_found_reg <= out_found_next;
        out_last_reg  <= out_last_next;
    end

    // Checks
    a_remove_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.mode == MODE_REMOVE) && slot_ok)
        |=> !valid_reg[$past(slot_idx)])
        else $error("remove did not free the slot");

    a_add_marks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> valid_reg[$past(scan_reg)])
        else $error("added slot not marked valid");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (state_reg == S_SCAN) && cur_vld_reg && (cur_reg == $past(cur_reg)))
        else $error("scan advanced during a stall");

    a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> (hits_reg != 4'd0) && (hits_reg <= MAX_HITS))
        else $error("held hit without hit count");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        emit_en |-> out_free)
        else $error("result written over an undelivered one");

endmodule

// File: tb/sv/box_overlap_collision_table_core_tb.sv
// ---------------------------------------------------------------------------
// box_overlap_collision_table_core_tb
// Self-checking bench for the box overlap collision table. A table of
// directed items covers the edges of the coordinate range, zero-size boxes,
// a full table, stale slots and the hit limit. Random items follow under
// several pair masks. Both sides idle at random. A local copy of the table
// predicts every result item that a directed row does not give, and each
// accepted result is compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module box_overlap_collision_table_core_tb;

    localparam int         SLOTS            = bocd_pkg::SLOTS_DEF;
    localparam logic [1:0] MODE_NOP         = 2'd3;
    localparam int         IDLE_LIMIT       = 2000;
    localparam int         DRAIN_CYCLES     = SLOTS + 8;
    localparam int         RANDOM_PER_PHASE = 91;

    // One request item and one result item
    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         slot;
        logic signed [15:0] left_x;
        logic signed [15:0] top_y;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [2:0]         box_type;
        logic               has_receiver;
    } table_item_t;

    typedef struct packed {
        logic [3:0] index;
        logic       found;
        logic       last;
    } report_t;

    // One row of the directed table; want is used only where typed is set
    typedef struct {
        table_item_t item;
        int          reps;
        bit          typed;
        report_t     want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    bocd_req_if req_ch();
    bocd_rsp_if rsp_ch();
    bocd_cfg_if cfg_ch();

    // Local copy of the table
    logic signed [16:0] box_l [SLOTS];
    logic signed [16:0] box_t [SLOTS];
    logic signed [16:0] box_r [SLOTS];
    logic signed [16:0] box_b [SLOTS];
    logic [2:0]         box_kind [SLOTS];
    bit                 box_recv [SLOTS];
    bit                 slot_used [SLOTS];
    logic [63:0]        notify_mask;

    report_t   pending_reports[$];
    stim_row_t stim_rows[$];
    int        failures;

    // Idle stretches for sender and receiver
    int src_left;
    int rcv_left;
    bit src_calm;
    bit rcv_calm;

    box_overlap_collision_table_core #(.SLOTS(SLOTS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap before the next item: busy and calm stretches are drawn at random
    function automatic int draw_wait(inout int left, inout bit calm);
        if (left == 0)
        begin
            left = $urandom_range(4, 24);
            calm = ($urandom_range(0, 3) == 0);
        end
        left--;
        return calm ? 0 : $urandom_range(0, 15);
    endfunction

    // Update the table copy and queue the result items the item causes, or want where typed is set
    task automatic apply_table_item(input table_item_t it, input bit typed,
                                    input report_t want);
        report_t outcome[$];
        int      k;
        int      s;
        bit      placed;
        s      = it.slot;
        placed = 1'b0;
        case (it.mode)
            bocd_pkg::MODE_ADD:
            begin
                for (k = 0; k < SLOTS; k++)
                begin
                    if (!placed && !slot_used[k])
                    begin
                        box_l[k]     = {it.left_x[15], it.left_x};
                        box_t[k]     = {it.top_y[15], it.top_y};
                        box_r[k]     = {it.left_x[15], it.left_x} + {2'b00, it.width};
                        box_b[k]     = {it.top_y[15], it.top_y} + {2'b00, it.height};
                        box_kind[k]  = it.box_type;
                        box_recv[k]  = it.has_receiver;
                        slot_used[k] = 1'b1;
                        placed       = 1'b1;
                        outcome.push_back('{index: 4'(k), found: 1'b1, last: 1'b1});
                    end
                end
                if (!placed)
                    outcome.push_back('{index: 4'd0, found: 1'b0, last: 1'b1});
            end
            bocd_pkg::MODE_REMOVE:
                slot_used[s] = 1'b0;
            bocd_pkg::MODE_QUERY:
            begin
                if (slot_used[s] && box_recv[s])
                begin
                    for (k = 0; k < SLOTS; k++)
                    begin
                        if (outcome.size() < bocd_pkg::MAX_HITS && k != s && slot_used[k]
                            && notify_mask[box_kind[s] * bocd_pkg::TYPES + box_kind[k]]
                            && box_l[s] < box_r[k] && box_r[s] > box_l[k]
                            && box_t[s] < box_b[k] && box_b[s] > box_t[k])
                            outcome.push_back('{index: 4'(k), found: 1'b1, last: 1'b0});
                    end
                end
                if (outcome.size() == 0)
                    outcome.push_back('{index: 4'd0, found: 1'b0, last: 1'b1});
                else
                    outcome[outcome.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
        if (typed)
            pending_reports.push_back(want);
        else
            foreach (outcome[j])
                pending_reports.push_back(outcome[j]);
    endtask

    // Present one request item and wait for it to be taken
    task automatic drive_item(input table_item_t it, input bit typed, input report_t want);
        int gap;
        gap = draw_wait(src_left, src_calm);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= it.mode;
        req_ch.slot         <= it.slot;
        req_ch.left_x       <= it.left_x;
        req_ch.top_y        <= it.top_y;
        req_ch.width        <= it.width;
        req_ch.height       <= it.height;
        req_ch.box_type     <= it.box_type;
        req_ch.has_receiver <= it.has_receiver;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        apply_table_item(it, typed, want);
    endtask

    // Write the pair mask once the block has gone quiet
    task automatic write_mask(input logic [63:0] value);
        req_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.pair_mask <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        notify_mask = value;
    endtask

    task automatic add_row(input logic [1:0] mode, input logic [3:0] slot,
                           input int x, input int y, input int w, input int h,
                           input int kind, input bit recv, input int reps,
                           input bit typed, input int idx, input bit fnd);
        stim_row_t row;
        row.item  = '{mode: mode, slot: slot, left_x: 16'(x), top_y: 16'(y),
                      width: 15'(w), height: 15'(h), box_type: 3'(kind),
                      has_receiver: recv};
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{index: 4'(idx), found: fnd, last: 1'b1};
        stim_rows.push_back(row);
    endtask

    // Random item: mostly small boxes clustered round the origin
    function automatic table_item_t random_item();
        table_item_t it;
        int          pick;
        pick    = $urandom_range(0, 99);
        it.mode = (pick < 35) ? bocd_pkg::MODE_ADD :
                  (pick < 65) ? bocd_pkg::MODE_REMOVE :
                  (pick < 97) ? bocd_pkg::MODE_QUERY : MODE_NOP;
        it.slot = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 4) == 0)
        begin
            it.left_x = 16'($urandom);
            it.top_y  = 16'($urandom);
            it.width  = 15'($urandom);
            it.height = 15'($urandom);
        end
        else
        begin
            it.left_x = 16'($urandom_range(0, 240)) - 16'd120;
            it.top_y  = 16'($urandom_range(0, 240)) - 16'd120;
            it.width  = 15'($urandom_range(0, 100));
            it.height = 15'($urandom_range(0, 100));
        end
        if ($urandom_range(0, 15) == 0)
            it.width = '0;
        if ($urandom_range(0, 15) == 0)
            it.height = '0;
        it.box_type     = 3'($urandom);
        it.has_receiver = ($urandom_range(0, 5) != 0);
        return it;
    endfunction

    // Stimulus
    initial
    begin
        logic [63:0] masks [4];
        int          counted;
        int          ones_from;
        table_item_t it;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= bocd_pkg::MODE_ADD;
        req_ch.slot         <= '0;
        req_ch.left_x       <= '0;
        req_ch.top_y        <= '0;
        req_ch.width        <= '0;
        req_ch.height       <= '0;
        req_ch.box_type     <= '0;
        req_ch.has_receiver <= 1'b0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.pair_mask    <= '0;
        failures    = 0;
        src_left    = 0;
        rcv_left    = 0;
        notify_mask = '0;
        foreach (slot_used[k])
            slot_used[k] = 1'b0;

        // Reset mask: nothing is notified, whatever overlaps
        add_row(bocd_pkg::MODE_QUERY,  0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(bocd_pkg::MODE_REMOVE, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(bocd_pkg::MODE_ADD, 9, -32768, -32768, 32767, 32767, 0, 1, 1, 1, 0, 1);
        add_row(bocd_pkg::MODE_ADD, 3, 32767, 32767, 32767, 32767, 7, 1, 1, 1, 1, 1);
        add_row(bocd_pkg::MODE_ADD, 0, -100, -100, 200, 200, 0, 1, 1, 1, 2, 1);
        add_row(bocd_pkg::MODE_QUERY,  2, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(MODE_NOP,              7, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        ones_from = stim_rows.size();
        // Every pair notified from here on
        add_row(bocd_pkg::MODE_QUERY,  2, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(bocd_pkg::MODE_QUERY,  1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // Zero-width box inside another one
        add_row(bocd_pkg::MODE_ADD,    0, 0, 0, 0, 10, 3, 1, 1, 1, 3, 1);
        add_row(bocd_pkg::MODE_QUERY,  3, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // Box without a receiver never reports
        add_row(bocd_pkg::MODE_ADD,    0, 0, 0, 50, 50, 5, 0, 1, 1, 4, 1);
        add_row(bocd_pkg::MODE_QUERY,  4, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        // Freed slot: stale query, then reused by the next add
        add_row(bocd_pkg::MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(bocd_pkg::MODE_QUERY,  0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0);
        add_row(bocd_pkg::MODE_ADD,    0, -10, -10, 20, 20, 2, 1, 1, 1, 0, 1);
        add_row(bocd_pkg::MODE_QUERY,  2, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // Fill the table, then one add too many
        add_row(bocd_pkg::MODE_ADD,    0, -5, -5, 10, 10, 6, 1, 11, 0, 0, 0);
        add_row(bocd_pkg::MODE_ADD,    0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0);
        add_row(bocd_pkg::MODE_QUERY,  0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        // Bring the hit count up to the limit: every other slot overlaps slot 0
        add_row(bocd_pkg::MODE_REMOVE, 1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(bocd_pkg::MODE_ADD,    0, 0, 0, 5, 5, 4, 0, 1, 1, 1, 1);
        add_row(bocd_pkg::MODE_REMOVE, 3, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(bocd_pkg::MODE_ADD,    0, 0, 0, 5, 5, 4, 0, 1, 1, 3, 1);
        add_row(bocd_pkg::MODE_QUERY,  0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part
        foreach (stim_rows[i])
        begin
            if (i == ones_from)
                write_mask('1);
            repeat (stim_rows[i].reps)
                drive_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
        end

        // Random part under several masks
        masks[0] = {$urandom, $urandom};
        masks[1] = '0;
        masks[2] = '1;
        masks[3] = {$urandom, $urandom} & {$urandom, $urandom};
        foreach (masks[p])
        begin
            write_mask(masks[p]);
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                it = random_item();
                drive_item(it, 1'b0, '0);
                if (it.mode != MODE_NOP)
                    counted++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain
        while (pending_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Result receiver and checker
    initial
    begin
        report_t want;
        int      stall;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(rcv_left, rcv_calm);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            if (pending_reports.size() == 0)
            begin
                $error("unexpected result item: index %0d found %0d last %0d",
                       rsp_ch.index, rsp_ch.found, rsp_ch.last);
                failures++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (rsp_ch.index !== want.index)
                begin
                    $error("index: expected %0d, actual %0d", want.index, rsp_ch.index);
                    failures++;
                end
                if (rsp_ch.found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                    failures++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no handshake for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

endmodule
